// ----- design/sem_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// sem_pkg
// Shared types and constants of the Sobel edge magnitude block: geometry
// widths, register indexes, the controller states and the command and status
// bundles between the controller and the datapath.
// ============================================================================
package sem_pkg;

    localparam int MAX_LINE_PIXELS = 2048;

    localparam int PIXEL_W     = 8;
    localparam int FRAME_W_W   = 12;
    localparam int FRAME_H_W   = 16;
    localparam int MODE_W      = 1;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 2;

    localparam int LINE_ADDR_W = $clog2(MAX_LINE_PIXELS);
    localparam int EFF_W_W     = LINE_ADDR_W + 1;
    localparam int CLAMP_W     = (FRAME_W_W > EFF_W_W) ? FRAME_W_W : EFF_W_W;

    // Weighted column or row sums reach 4 * 255, absolute gradients likewise.
    localparam int GRAD_W = PIXEL_W + 2;
    localparam int PROD_W = 2 * GRAD_W;
    localparam int SQ_W   = 2 * GRAD_W + 1;

    localparam logic [PIXEL_W-1:0] EDGE_MAX = 8'd255;

    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAGNITUDE_MODE = 2'd2;

    localparam logic [FRAME_W_W-1:0] FRAME_WIDTH_RESET  = 12'd512;
    localparam logic [FRAME_H_W-1:0] FRAME_HEIGHT_RESET = 16'd512;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GRAD,
        ST_MAG,
        ST_SQ_INIT,
        ST_SQRT,
        ST_SAT,
        ST_EMIT
    } sem_state_t;

    typedef struct packed {
        logic capture;
        logic drain;
        logic grad;
        logic mag;
        logic sq_init;
        logic sqrt_step;
        logic take_root;
        logic load_out;
    } sem_cmd_t;

    typedef struct packed {
        logic pending;
        logic emit;
        logic border;
        logic mode;
        logic sqrt_last;
        logic out_busy;
    } sem_status_t;

endpackage

// ----- design/sem_stream_if.sv -----
`timescale 1ns / 1ps
// ============================================================================
// sem_stream_if
// Valid/ready stream interfaces for the pixel input and the edge result
// output of the Sobel edge magnitude block.
// ============================================================================
interface sem_pixel_if;
    logic                        valid;
    logic                        ready;
    logic [sem_pkg::PIXEL_W-1:0] pixel;
    logic                        drain;

    modport source (output valid, output pixel, output drain, input ready);
    modport sink   (input valid, input pixel, input drain, output ready);
endinterface

interface sem_result_if;
    logic                        valid;
    logic                        ready;
    logic [sem_pkg::PIXEL_W-1:0] edge_value;
    logic                        frame_end;

    modport source (output valid, output edge_value, output frame_end, input ready);
    modport sink   (input valid, input edge_value, input frame_end, output ready);
endinterface

// ----- design/sem_ram.sv -----
`timescale 1ns / 1ps
// ============================================================================
// sem_ram
// Generic simple dual-port RAM with one write port and one registered read
// port.
// ============================================================================
module sem_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/sem_ctrl.sv -----
`timescale 1ns / 1ps
// ============================================================================
// sem_ctrl
// Controller of the Sobel edge magnitude block. It accepts one beat at a
// time and steps the datapath through gradient, magnitude and output.
// ============================================================================
module sem_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    sem_pixel_if.sink            pixel_stream,
    input  sem_pkg::sem_status_t status,
    output sem_pkg::sem_cmd_t    cmd
);

    sem_pkg::sem_state_t state_reg;
    sem_pkg::sem_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sem_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next         = state_reg;
        cmd                = '0;
        pixel_stream.ready = 1'b0;
        unique case (state_reg)
            sem_pkg::ST_IDLE:
            begin
                pixel_stream.ready = 1'b1;
                if (pixel_stream.valid)
                begin
                    if (pixel_stream.drain)
                    begin
                        if (status.pending)
                        begin
                            cmd.drain  = 1'b1;
                            state_next = sem_pkg::ST_EMIT;
                        end
                    end
                    else
                    begin
                        cmd.capture = 1'b1;
                        state_next  = sem_pkg::ST_GRAD;
                    end
                end
            end
            sem_pkg::ST_GRAD:
            begin
                cmd.grad = 1'b1;
                priority if (!status.emit)
                begin
                    state_next = sem_pkg::ST_IDLE;
                end
                else if (status.border)
                begin
                    state_next = sem_pkg::ST_EMIT;
                end
                else
                begin
                    state_next = sem_pkg::ST_MAG;
                end
            end
            sem_pkg::ST_MAG:
            begin
                cmd.mag    = 1'b1;
                state_next = status.mode ? sem_pkg::ST_EMIT : sem_pkg::ST_SQ_INIT;
            end
            sem_pkg::ST_SQ_INIT:
            begin
                cmd.sq_init = 1'b1;
                state_next  = sem_pkg::ST_SQRT;
            end
            sem_pkg::ST_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                if (status.sqrt_last)
                begin
                    state_next = sem_pkg::ST_SAT;
                end
            end
            sem_pkg::ST_SAT:
            begin
                cmd.take_root = 1'b1;
                state_next    = sem_pkg::ST_EMIT;
            end
            sem_pkg::ST_EMIT:
            begin
                if (!status.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = sem_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sem_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- design/sem_datapath.sv -----
`timescale 1ns / 1ps
// ============================================================================
// sem_datapath
// Datapath of the Sobel edge magnitude block: configuration registers,
// position counters, line stores, the 3x3 window, gradient arithmetic, an
// iterative square root and the output register.
// ============================================================================
module sem_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [sem_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [sem_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic [sem_pkg::PIXEL_W-1:0]       pixel,
    sem_result_if.source                      edge_stream,
    input  sem_pkg::sem_cmd_t                 cmd,
    output sem_pkg::sem_status_t              status
);

    localparam int AW = sem_pkg::LINE_ADDR_W;
    localparam int EW = sem_pkg::EFF_W_W;
    localparam int HW = sem_pkg::FRAME_H_W;
    localparam int PW = sem_pkg::PIXEL_W;
    localparam int GW = sem_pkg::GRAD_W;
    localparam int SW = sem_pkg::SQ_W;

    // Configuration and control state.
    logic [sem_pkg::FRAME_W_W-1:0] frame_width_reg, frame_width_next;
    logic [HW-1:0]                 frame_height_reg, frame_height_next;
    logic                          mode_reg, mode_next;
    logic [AW-1:0]                 in_col_reg, in_col_next;
    logic [HW-1:0]                 in_row_reg, in_row_next;
    logic [AW-1:0]                 out_col_reg, out_col_next;
    logic [HW-1:0]                 out_row_reg, out_row_next;
    logic [EW-1:0]                 lag_reg, lag_next;
    logic [PW-1:0]                 win_reg [6];
    logic [PW-1:0]                 win_next [6];
    logic                          out_valid_reg, out_valid_next;

    // Payload state.
    logic [PW-1:0]                   pix_reg;
    logic [GW-1:0]                   ax_reg, ay_reg;
    logic [sem_pkg::PROD_W-1:0]      prod_reg, prod_next;
    logic [SW-1:0]                   v_reg, v_next;
    logic [SW-1:0]                   r_reg, r_next;
    logic [SW-1:0]                   bit_reg, bit_next;
    logic [PW-1:0]                   res_reg, res_next;
    logic                            last_reg, last_next;
    logic [PW-1:0]                   edge_value_reg;
    logic                            frame_end_reg;

    // Derived geometry.
    logic [sem_pkg::CLAMP_W-1:0] fw_ext;
    logic [EW-1:0]               eff_w;
    logic [HW-1:0]               eff_h;
    logic                        restart;
    logic                        in_col_wrap, in_row_wrap, out_col_wrap, out_row_wrap;
    logic                        border, last_pos, emit;

    // Line stores.
    logic [PW-1:0] upper_rdata, middle_rdata;

    // Gradient arithmetic.
    logic [GW-1:0] sum_right, sum_left, sum_bottom, sum_top;
    logic [GW-1:0] ax_next, ay_next;
    logic [GW:0]   abs_sum;
    logic [GW-1:0] half_sum;
    logic [SW-1:0] trial;

    assign fw_ext = sem_pkg::CLAMP_W'(frame_width_reg);

    always_comb
    begin
        priority if (fw_ext < sem_pkg::CLAMP_W'(3))
        begin
            eff_w = EW'(3);
        end
        else if (fw_ext > sem_pkg::CLAMP_W'(sem_pkg::MAX_LINE_PIXELS))
        begin
            eff_w = EW'(sem_pkg::MAX_LINE_PIXELS);
        end
        else
        begin
            eff_w = EW'(fw_ext);
        end
    end

    assign eff_h = (frame_height_reg < HW'(3)) ? HW'(3) : frame_height_reg;

    assign restart = cfg_write && ((cfg_index == sem_pkg::CFG_FRAME_WIDTH) ||
                                   (cfg_index == sem_pkg::CFG_FRAME_HEIGHT));

    assign in_col_wrap  = (EW'(in_col_reg) + EW'(1)) >= eff_w;
    assign in_row_wrap  = ((HW + 1)'(in_row_reg) + (HW + 1)'(1)) >= (HW + 1)'(eff_h);
    assign out_col_wrap = (EW'(out_col_reg) + EW'(1)) >= eff_w;
    assign out_row_wrap = ((HW + 1)'(out_row_reg) + (HW + 1)'(1)) >= (HW + 1)'(eff_h);

    assign border = !((out_row_reg >= HW'(1)) && (out_row_reg <= eff_h - HW'(2)) &&
                      (EW'(out_col_reg) >= EW'(1)) && (EW'(out_col_reg) <= eff_w - EW'(2)));
    assign last_pos = (out_row_reg == eff_h - HW'(1)) && (EW'(out_col_reg) == eff_w - EW'(1));
    assign emit     = (EW + 1)'(lag_reg) >= ((EW + 1)'(eff_w) + (EW + 1)'(1));

    sem_ram #(
        .DATA_W (PW),
        .DEPTH  (sem_pkg::MAX_LINE_PIXELS)
    ) u_upper_store (
        .clk   (clk),
        .we    (cmd.grad),
        .waddr (in_col_reg),
        .wdata (middle_rdata),
        .re    (cmd.capture),
        .raddr (in_col_reg),
        .rdata (upper_rdata)
    );

    sem_ram #(
        .DATA_W (PW),
        .DEPTH  (sem_pkg::MAX_LINE_PIXELS)
    ) u_middle_store (
        .clk   (clk),
        .we    (cmd.grad),
        .waddr (in_col_reg),
        .wdata (pix_reg),
        .re    (cmd.capture),
        .raddr (in_col_reg),
        .rdata (middle_rdata)
    );

    // The window holds the left column in entries 0 to 2 and the center
    // column in entries 3 to 5, each top to bottom. The right column comes
    // from the two line stores and the new pixel.
    assign sum_right  = GW'(upper_rdata) + {1'b0, middle_rdata, 1'b0} + GW'(pix_reg);
    assign sum_left   = GW'(win_reg[0]) + {1'b0, win_reg[1], 1'b0} + GW'(win_reg[2]);
    assign sum_bottom = GW'(win_reg[2]) + {1'b0, win_reg[5], 1'b0} + GW'(pix_reg);
    assign sum_top    = GW'(win_reg[0]) + {1'b0, win_reg[3], 1'b0} + GW'(upper_rdata);

    assign ax_next = (sum_right >= sum_left) ? sum_right - sum_left : sum_left - sum_right;
    assign ay_next = (sum_bottom >= sum_top) ? sum_bottom - sum_top : sum_top - sum_bottom;

    assign abs_sum  = (GW + 1)'(ax_reg) + (GW + 1)'(ay_reg);
    assign half_sum = abs_sum[GW:1];
    assign trial    = r_reg + bit_reg;

    always_comb
    begin
        frame_width_next  = frame_width_reg;
        frame_height_next = frame_height_reg;
        mode_next         = mode_reg;
        in_col_next       = in_col_reg;
        in_row_next       = in_row_reg;
        out_col_next      = out_col_reg;
        out_row_next      = out_row_reg;
        lag_next          = lag_reg;
        win_next          = win_reg;
        out_valid_next    = out_valid_reg;
        prod_next         = prod_reg;
        v_next            = v_reg;
        r_next            = r_reg;
        bit_next          = bit_reg;
        res_next          = res_reg;
        last_next         = last_reg;

        if (edge_stream.valid && edge_stream.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end

        if (cmd.drain || (cmd.grad && emit))
        begin
            last_next = last_pos;
            if (out_col_wrap)
            begin
                out_col_next = '0;
                out_row_next = out_row_wrap ? '0 : out_row_reg + HW'(1);
            end
            else
            begin
                out_col_next = out_col_reg + AW'(1);
            end
        end

        if (cmd.drain)
        begin
            lag_next = lag_reg - EW'(1);
            res_next = '0;
        end

        if (cmd.grad)
        begin
            res_next    = '0;
            win_next[0] = win_reg[3];
            win_next[1] = win_reg[4];
            win_next[2] = win_reg[5];
            win_next[3] = upper_rdata;
            win_next[4] = middle_rdata;
            win_next[5] = pix_reg;
            if (!emit)
            begin
                lag_next = lag_reg + EW'(1);
            end
            if (in_col_wrap)
            begin
                in_col_next = '0;
                in_row_next = in_row_wrap ? '0 : in_row_reg + HW'(1);
            end
            else
            begin
                in_col_next = in_col_reg + AW'(1);
            end
        end

        if (cmd.mag)
        begin
            prod_next = sem_pkg::PROD_W'(ax_reg) * sem_pkg::PROD_W'(ax_reg);
            res_next  = (half_sum > GW'(sem_pkg::EDGE_MAX)) ? sem_pkg::EDGE_MAX
                                                            : half_sum[PW-1:0];
        end

        if (cmd.sq_init)
        begin
            v_next   = SW'(prod_reg) + SW'(ay_reg) * SW'(ay_reg);
            r_next   = '0;
            bit_next = SW'(1) << (SW - 1);
        end

        if (cmd.sqrt_step)
        begin
            if (v_reg >= trial)
            begin
                v_next = v_reg - trial;
                r_next = (r_reg >> 1) + bit_reg;
            end
            else
            begin
                r_next = r_reg >> 1;
            end
            bit_next = bit_reg >> 2;
        end

        if (cmd.take_root)
        begin
            res_next = (r_reg > SW'(sem_pkg::EDGE_MAX)) ? sem_pkg::EDGE_MAX : r_reg[PW-1:0];
        end

        if (cfg_write)
        begin
            unique case (cfg_index)
                sem_pkg::CFG_FRAME_WIDTH:
                begin
                    frame_width_next = cfg_data[sem_pkg::FRAME_W_W-1:0];
                end
                sem_pkg::CFG_FRAME_HEIGHT:
                begin
                    frame_height_next = cfg_data[HW-1:0];
                end
                sem_pkg::CFG_MAGNITUDE_MODE:
                begin
                    mode_next = cfg_data[0];
                end
                default:
                begin
                end
            endcase
        end

        if (restart)
        begin
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
            lag_next     = '0;
            for (int i = 0; i < 6; i++)
            begin
                win_next[i] = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= sem_pkg::FRAME_WIDTH_RESET;
            frame_height_reg <= sem_pkg::FRAME_HEIGHT_RESET;
            mode_reg         <= 1'b0;
            in_col_reg       <= '0;
            in_row_reg       <= '0;
            out_col_reg      <= '0;
            out_row_reg      <= '0;
            lag_reg          <= '0;
            out_valid_reg    <= 1'b0;
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else
        begin
            frame_width_reg  <= frame_width_next;
            frame_height_reg <= frame_height_next;
            mode_reg         <= mode_next;
            in_col_reg       <= in_col_next;
            in_row_reg       <= in_row_next;
            out_col_reg      <= out_col_next;
            out_row_reg      <= out_row_next;
            lag_reg          <= lag_next;
            out_valid_reg    <= out_valid_next;
            win_reg          <= win_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            pix_reg <= pixel;
        end
        if (cmd.grad)
        begin
            ax_reg <= ax_next;
            ay_reg <= ay_next;
        end
        if (cmd.load_out)
        begin
            edge_value_reg <= res_reg;
            frame_end_reg  <= last_reg;
        end
        prod_reg <= prod_next;
        v_reg    <= v_next;
        r_reg    <= r_next;
        bit_reg  <= bit_next;
        res_reg  <= res_next;
        last_reg <= last_next;
    end

    assign edge_stream.valid      = out_valid_reg;
    assign edge_stream.edge_value = edge_value_reg;
    assign edge_stream.frame_end  = frame_end_reg;

    assign status.pending   = (lag_reg != '0);
    assign status.emit      = emit;
    assign status.border    = border;
    assign status.mode      = mode_reg;
    assign status.sqrt_last = bit_reg[0];
    assign status.out_busy  = out_valid_reg && !edge_stream.ready;

endmodule

// ----- design/sobel_edge_magnitude.sv -----
`timescale 1ns / 1ps
// ============================================================================
// sobel_edge_magnitude
// Streaming 3x3 Sobel edge magnitude over 8-bit grey pixels in raster order.
// ============================================================================
// The block takes one beat at a time. Each pixel is captured and its
// gradients are computed; a pixel that produces no result yet ends there.
// A border result is zero. A drain beat emits a zero result, or none when
// nothing is pending. Other results follow the mode: the halved absolute sum
// or the exact square root, found in the 11 steps of the bit-pair unit. A
// waiting result sits in an output register, so the next beat is taken while
// it waits and is only held back once a new result is ready. The result for a
// position leaves one line and one pixel after it was fed in; drain beats
// flush the tail of a frame. Writing the frame width or height restarts the
// frame; configure only while the block is idle.
module sobel_edge_magnitude (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [sem_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [sem_pkg::CFG_DATA_W-1:0]  cfg_data,
    sem_pixel_if.sink                       pixel_stream,
    sem_result_if.source                    edge_stream
);

    sem_pkg::sem_cmd_t    cmd;
    sem_pkg::sem_status_t status;

    sem_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_stream (pixel_stream),
        .status       (status),
        .cmd          (cmd)
    );

    sem_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pixel       (pixel_stream.pixel),
        .edge_stream (edge_stream),
        .cmd         (cmd),
        .status      (status)
    );

endmodule

// ----- verif/sobel_edge_magnitude_tb.sv -----
`timescale 1ns / 1ps
// ============================================================================
// sobel_edge_magnitude_tb
// Self-checking bench for the streaming Sobel edge magnitude block. A driver
// feeds pixel and drain beats from a queue in random bursts. A monitor keeps
// its own model of the line stores, the window and the position counters,
// predicts each edge beat and checks it field by field. Frame geometry and
// magnitude mode are rewritten between phases, the extreme settings included.
// ============================================================================
module sobel_edge_magnitude_tb;

    localparam int TOTAL_ITEMS   = 1700;
    localparam int WIDE_PIXELS   = sem_pkg::MAX_LINE_PIXELS / 2;
    localparam int SETTLE_CYCLES = 40;
    localparam int LONG_HOLD     = 400;
    localparam int TIMEOUT_NS    = 10_000_000;

    typedef struct packed {
        logic [sem_pkg::PIXEL_W-1:0] pixel;
        logic                        drain;
    } pixel_beat_t;

    typedef struct packed {
        logic [sem_pkg::PIXEL_W-1:0] edge_value;
        logic                        frame_end;
    } edge_beat_t;

    typedef enum {RX_ALWAYS, RX_HALF, RX_MOSTLY, RX_PATTERN} rx_mode_t;
    typedef enum {PX_RANDOM, PX_EXTREME, PX_SMOOTH} pixel_style_t;
    typedef enum {PH_FRAMES, PH_NOISE} phase_kind_t;

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_write;
    logic [sem_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [sem_pkg::CFG_DATA_W-1:0]  cfg_data;

    sem_pixel_if  px_if ();
    sem_result_if edge_if ();

    sobel_edge_magnitude i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pixel_stream (px_if),
        .edge_stream  (edge_if)
    );

    pixel_beat_t pixel_queue[$];
    edge_beat_t  edges_due[$];
    int          errors = 0;
    int          queued_items = 0;

    // Model state of the block.
    logic [sem_pkg::FRAME_W_W-1:0] cfg_width;
    logic [sem_pkg::FRAME_H_W-1:0] cfg_height;
    logic                          cfg_mode;
    logic [sem_pkg::PIXEL_W-1:0]   upper_line [sem_pkg::MAX_LINE_PIXELS];
    logic [sem_pkg::PIXEL_W-1:0]   middle_line [sem_pkg::MAX_LINE_PIXELS];
    logic [sem_pkg::PIXEL_W-1:0]   win [6];
    int                            in_col, in_row, out_col, out_row;

    // Handshake and idling state.
    logic        pixel_taken = 1'b0;
    pixel_beat_t beat_now = '0;
    logic        offer;
    int          burst_left = 0;
    int          gap_left = 0;
    logic        rdy;
    rx_mode_t    rx_mode = RX_ALWAYS;
    int          rx_mode_left = 0;
    logic [15:0] rx_pattern = 16'hFFFF;
    int          hold_left = 0;
    int          stall_ticket = 0;
    int          stall_seen = 0;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic int eff_width();
        int w;
        w = int'(cfg_width);
        if (w < 3)
            return 3;
        if (w > sem_pkg::MAX_LINE_PIXELS)
            return sem_pkg::MAX_LINE_PIXELS;
        return w;
    endfunction

    function automatic int eff_height();
        int h;
        h = int'(cfg_height);
        return (h < 3) ? 3 : h;
    endfunction

    function automatic void step_pos(inout int col, inout int row, input int w, input int h);
        col++;
        if (col >= w)
        begin
            col = 0;
            row++;
            if (row >= h)
                row = 0;
        end
    endfunction

    function automatic void restart_frame();
        foreach (win[i])
            win[i] = '0;
        in_col  = 0;
        in_row  = 0;
        out_col = 0;
        out_row = 0;
    endfunction

    function automatic void sobel_config(logic [sem_pkg::CFG_INDEX_W-1:0] idx,
                                         logic [sem_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            sem_pkg::CFG_FRAME_WIDTH:
            begin
                cfg_width = data[sem_pkg::FRAME_W_W-1:0];
                restart_frame();
            end
            sem_pkg::CFG_FRAME_HEIGHT:
            begin
                cfg_height = data[sem_pkg::FRAME_H_W-1:0];
                restart_frame();
            end
            sem_pkg::CFG_MAGNITUDE_MODE:
                cfg_mode = data[0];
            default: ;
        endcase
    endfunction

    function automatic void sobel_step(logic [sem_pkg::PIXEL_W-1:0] pix, logic drn);
        int                          w, h, ic, gx, gy, ax, ay, sum, root;
        longint                      frame, ipos, opos, lag;
        logic [sem_pkg::PIXEL_W-1:0] t[3], m[3], b[3];
        edge_beat_t                  res;
        w     = eff_width();
        h     = eff_height();
        frame = longint'(w) * h;
        ipos  = longint'(in_row) * w + in_col;
        opos  = longint'(out_row) * w + out_col;
        lag   = (ipos + frame - opos) % frame;
        if (drn)
        begin
            if (lag != 0)
            begin
                res.edge_value = '0;
                res.frame_end  = (out_row == h - 1) && (out_col == w - 1);
                edges_due.push_back(res);
                step_pos(out_col, out_row, w, h);
            end
            return;
        end
        ic   = in_col;
        t[0] = win[0];
        m[0] = win[1];
        b[0] = win[2];
        t[1] = win[3];
        m[1] = win[4];
        b[1] = win[5];
        t[2] = upper_line[ic];
        m[2] = middle_line[ic];
        b[2] = pix;
        upper_line[ic]  = m[2];
        middle_line[ic] = pix;
        win[0] = t[1];
        win[1] = m[1];
        win[2] = b[1];
        win[3] = t[2];
        win[4] = m[2];
        win[5] = b[2];
        step_pos(in_col, in_row, w, h);
        if (lag < longint'(w) + 1)
            return;
        root = 0;
        if (out_row >= 1 && out_row <= h - 2 && out_col >= 1 && out_col <= w - 2)
        begin
            gx = (int'(t[2]) + 2 * int'(m[2]) + int'(b[2]))
               - (int'(t[0]) + 2 * int'(m[0]) + int'(b[0]));
            gy = (int'(b[0]) + 2 * int'(b[1]) + int'(b[2]))
               - (int'(t[0]) + 2 * int'(t[1]) + int'(t[2]));
            ax = (gx < 0) ? -gx : gx;
            ay = (gy < 0) ? -gy : gy;
            if (cfg_mode == 1'b0)
            begin
                sum = ax * ax + ay * ay;
                while (root < 255 && (root + 1) * (root + 1) <= sum)
                    root++;
            end
            else
            begin
                root = (ax + ay) >> 1;
                if (root > 255)
                    root = 255;
            end
        end
        res.edge_value = root[sem_pkg::PIXEL_W-1:0];
        res.frame_end  = (out_row == h - 1) && (out_col == w - 1);
        edges_due.push_back(res);
        step_pos(out_col, out_row, w, h);
    endfunction

    always @(posedge clk)
    begin
        edge_beat_t due;
        if (rst_n && edge_if.valid && edge_if.ready)
        begin
            if (edges_due.size() == 0)
            begin
                $error("unexpected edge beat: edge_value %0d, frame_end %0d",
                       edge_if.edge_value, edge_if.frame_end);
                errors++;
            end
            else
            begin
                due = edges_due.pop_front();
                if (edge_if.edge_value !== due.edge_value)
                begin
                    $error("edge_value mismatch: expected %0d, actual %0d",
                           due.edge_value, edge_if.edge_value);
                    errors++;
                end
                if (edge_if.frame_end !== due.frame_end)
                begin
                    $error("frame_end mismatch: expected %0d, actual %0d",
                           due.frame_end, edge_if.frame_end);
                    errors++;
                end
            end
        end
        pixel_taken = rst_n && px_if.valid && px_if.ready;
        if (pixel_taken)
            sobel_step(px_if.pixel, px_if.drain);
    end

    always @(negedge clk)
    begin
        offer = px_if.valid && !pixel_taken;
        if (!rst_n)
            offer = 1'b0;
        else if (!offer)
        begin
            if (gap_left > 0)
                gap_left--;
            else if (pixel_queue.size() != 0)
            begin
                beat_now = pixel_queue.pop_front();
                offer = 1'b1;
                if (burst_left > 1)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                end
            end
        end
        px_if.valid <= offer;
        px_if.pixel <= beat_now.pixel;
        px_if.drain <= beat_now.drain;
    end

    always @(negedge clk)
    begin
        if (stall_ticket != stall_seen)
        begin
            stall_seen = stall_ticket;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rdy = 1'b0;
        end
        else
        begin
            if (rx_mode_left == 0)
            begin
                rx_mode = rx_mode_t'($urandom_range(0, 3));
                rx_mode_left = $urandom_range(32, 256);
                rx_pattern = 16'($urandom);
            end
            else
                rx_mode_left--;
            case (rx_mode)
                RX_ALWAYS:  rdy = 1'b1;
                RX_HALF:    rdy = 1'($urandom_range(0, 1));
                RX_MOSTLY:  rdy = ($urandom_range(0, 9) != 0);
                default:
                begin
                    rdy = rx_pattern[0];
                    rx_pattern = {rx_pattern[0], rx_pattern[15:1]};
                end
            endcase
        end
        edge_if.ready <= rdy;
    end

    task automatic push_pixel(input logic [sem_pkg::PIXEL_W-1:0] p);
        pixel_queue.push_back(pixel_beat_t'{pixel: p, drain: 1'b0});
        queued_items++;
    endtask

    task automatic push_drain();
        pixel_queue.push_back(pixel_beat_t'{pixel: sem_pkg::PIXEL_W'($urandom), drain: 1'b1});
        queued_items++;
    endtask

    task automatic push_rows(input int v[9]);
        foreach (v[i])
            push_pixel(v[i][sem_pkg::PIXEL_W-1:0]);
    endtask

    task automatic wait_idle();
        while (pixel_queue.size() != 0 || px_if.valid || edges_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [sem_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [sem_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        sobel_config(idx, data);
        @(negedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_phase(input bit pressure, input bit new_geometry);
        int                            choice, w, h, nfr, npix, ndrain, base, slope, r;
        logic [sem_pkg::FRAME_W_W-1:0] wval;
        logic [sem_pkg::FRAME_H_W-1:0] hval;
        pixel_style_t                  style;
        phase_kind_t                   kind;
        choice = new_geometry ? 0 : $urandom_range(0, 3);
        if (choice == 0 || choice == 1)
        begin
            r = $urandom_range(0, 7);
            if (r == 0)
                wval = sem_pkg::FRAME_W_W'($urandom_range(0, 2));
            else if (r <= 4)
                wval = sem_pkg::FRAME_W_W'($urandom_range(3, 6));
            else if (r <= 6)
                wval = sem_pkg::FRAME_W_W'($urandom_range(7, 16));
            else
                wval = sem_pkg::FRAME_W_W'($urandom_range(17, 40));
            write_reg(sem_pkg::CFG_FRAME_WIDTH, {4'($urandom), wval});
        end
        if (choice == 0 || choice == 2)
        begin
            r = $urandom_range(0, 7);
            if (r == 0)
                hval = sem_pkg::FRAME_H_W'($urandom_range(0, 2));
            else if (r == 1)
                hval = $urandom_range(0, 1) ? 16'hFFFF : 16'($urandom_range(65, 65534));
            else
                hval = sem_pkg::FRAME_H_W'($urandom_range(3, 6));
            write_reg(sem_pkg::CFG_FRAME_HEIGHT, hval);
        end
        write_reg(sem_pkg::CFG_MAGNITUDE_MODE, sem_pkg::CFG_DATA_W'($urandom));
        w = eff_width();
        h = eff_height();
        kind = (pressure || $urandom_range(0, 9) < 7) ? PH_FRAMES : PH_NOISE;
        if (kind == PH_FRAMES)
        begin
            nfr = $urandom_range(1, 2);
            for (int f = 0; f < nfr; f++)
            begin
                style = pixel_style_t'($urandom_range(0, 2));
                base  = $urandom_range(0, 255);
                slope = $urandom_range(0, 40);
                npix  = (h <= 64) ? w * h : $urandom_range(2 * w + 2, 6 * w);
                for (int i = 0; i < npix; i++)
                begin
                    if (!pressure && f == 0 && i == npix / 2 && $urandom_range(0, 3) == 0)
                        wait_idle();
                    case (style)
                        PX_RANDOM:  push_pixel(sem_pkg::PIXEL_W'($urandom));
                        PX_EXTREME: push_pixel($urandom_range(0, 1) ? 8'd255 : 8'd0);
                        default:
                            push_pixel(sem_pkg::PIXEL_W'(base + (i % w) * slope
                                                         + $urandom_range(0, 3)));
                    endcase
                end
            end
        end
        else
        begin
            npix = $urandom_range(5, 4 * w + 10);
            repeat (npix)
            begin
                if ($urandom_range(0, 5) == 0)
                    push_drain();
                else
                    push_pixel(sem_pkg::PIXEL_W'($urandom));
            end
        end
        case ($urandom_range(0, 3))
            0:       ndrain = 0;
            1:       ndrain = $urandom_range(1, w);
            default: ndrain = w + 1 + $urandom_range(0, 3);
        endcase
        repeat (ndrain) push_drain();
        if (pressure)
            stall_ticket++;
    endtask

    initial
    begin
        int                            phase_no;
        logic [sem_pkg::FRAME_W_W-1:0] wide_width;
        cfg_width  = sem_pkg::FRAME_WIDTH_RESET;
        cfg_height = sem_pkg::FRAME_HEIGHT_RESET;
        cfg_mode   = 1'b0;
        foreach (upper_line[i])
        begin
            upper_line[i]  = '0;
            middle_line[i] = '0;
        end
        restart_frame();
        rst_n         = 1'b0;
        cfg_write     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        px_if.valid   = 1'b0;
        px_if.pixel   = '0;
        px_if.drain   = 1'b0;
        edge_if.ready = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A drain right after reset finds nothing pending.
        push_drain();
        wait_idle();
        // Width and height below the minimum are raised to three.
        write_reg(sem_pkg::CFG_FRAME_WIDTH, 16'd2);
        write_reg(sem_pkg::CFG_FRAME_HEIGHT, 16'd0);
        write_reg(sem_pkg::CFG_MAGNITUDE_MODE, 16'd0);
        push_rows('{0, 0, 255, 0, 0, 255, 0, 0, 255});
        repeat (4) push_drain();
        wait_idle();
        write_reg(sem_pkg::CFG_MAGNITUDE_MODE, 16'd1);
        push_rows('{10, 20, 30, 40, 50, 60, 70, 80, 90});
        repeat (4) push_drain();
        wait_idle();

        // Widest line, possibly clamped from a larger value, and tallest frame.
        wide_width = $urandom_range(0, 1) ? 12'd2048 : 12'($urandom_range(2049, 4095));
        write_reg(sem_pkg::CFG_FRAME_WIDTH, {4'($urandom), wide_width});
        write_reg(sem_pkg::CFG_FRAME_HEIGHT, 16'hFFFF);
        repeat (WIDE_PIXELS) push_pixel(sem_pkg::PIXEL_W'($urandom));
        repeat (8) push_drain();
        wait_idle();

        phase_no = 0;
        while (queued_items < TOTAL_ITEMS)
        begin
            run_phase(phase_no == 0 || $urandom_range(0, 11) == 0, phase_no == 0);
            wait_idle();
            phase_no++;
        end

        if (errors == 0 && edges_due.size() == 0)
            $display("sobel_edge_magnitude test passed");
        else
            $display("sobel_edge_magnitude test failed");
        $finish;
    end

    initial
    begin
        #TIMEOUT_NS;
        $display("sobel_edge_magnitude test failed");
        $finish;
    end

endmodule
